// ===== rtl/stx_pkg.sv =====
// shared types and constants of the span texture interpolator
`timescale 1ns / 1ps

package stx_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned AccW     = CoordW + FracW;
  localparam int unsigned TexelW   = 8;
  localparam int unsigned TexAddrW = 16;
  localparam int unsigned TexDepth = 65536;
  localparam int unsigned RecipW   = AccW + 1;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_SPAN = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [TexAddrW-1:0] texel_address;
    logic [TexelW-1:0]   texel_value;
    logic [CoordW-1:0]   u_start;
    logic [CoordW-1:0]   u_end;
    logic [CoordW-1:0]   v_start;
    logic [CoordW-1:0]   v_end;
  } stx_in_t;

  typedef struct packed {
    logic [TexelW-1:0] pixel;
    logic              span_last;
  } stx_out_t;

  // item after step preparation, ready for the span sequencer
  typedef struct packed {
    mode_e                   mode;
    logic [TexAddrW-1:0]     texel_address;
    logic [TexelW-1:0]       texel_value;
    logic [AccW-1:0]         u_acc;
    logic [AccW-1:0]         v_acc;
    logic signed [AccW-1:0]  u_inc;
    logic signed [AccW-1:0]  v_inc;
  } stx_item_t;

  typedef struct packed {
    logic issue;
    logic last;
  } stx_rd_req_t;

  typedef struct packed {
    logic credit;
  } stx_fifo_stat_t;

endpackage

// ===== rtl/span_texture_interpolator.sv =====
// top level: step preparation, span sequencer, texture ram and result fifo
`timescale 1ns / 1ps

// path: step stages a, b and c, the sequencer, the ram read register, the result fifo
// throughput: one texel load per cycle while no span is stepping; span pixels one per
//   cycle while the fifo has credit, set by the single read port of the texture ram
// reset: control state and accumulators cleared at once, texture contents
//   undefined until written, no clearing pass

module span_texture_interpolator import stx_pkg::*; #(
  parameter int unsigned SPAN_LENGTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stx_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stx_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(SPAN_LENGTH);
  // widest per-pixel step: |end - start| * 256 / SPAN_LENGTH, plus sign
  localparam int unsigned IncW = AccW + 1 - ($clog2(SPAN_LENGTH + 1) - 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(SPAN_LENGTH - 1);

  // prepared item from the step pipeline
  logic      item_valid, item_ready;
  stx_item_t item;

  // sequencer state
  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [AccW-1:0]        u_acc_q, u_acc_d, v_acc_q, v_acc_d;
  logic signed [IncW-1:0] u_inc_q, u_inc_d, v_inc_q, v_inc_d;

  // ram and fifo side
  logic                ram_we;
  logic [TexAddrW-1:0] ram_raddr;
  logic [TexelW-1:0]   ram_rdata;
  stx_rd_req_t         rd_req;
  stx_fifo_stat_t      fifo_stat;

  stx_step #(
    .SPAN_LENGTH (SPAN_LENGTH)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // loads need no result space, spans need room for their first pixel
  assign item_ready = !busy_q && ((item.mode == MODE_LOAD) || fifo_stat.credit);

  // span sequencer: the take cycle reads pixel 0 from the start coordinates,
  // the following cycles step the accumulators, one ram read each with fifo credit
  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    u_acc_d   = u_acc_q;
    v_acc_d   = v_acc_q;
    u_inc_d   = u_inc_q;
    v_inc_d   = v_inc_q;
    ram_we    = 1'b0;
    rd_req    = '0;
    // row from the integer byte of u, column from the integer byte of v
    ram_raddr = {u_acc_q[FracW +: 8], v_acc_q[FracW +: 8]};

    if (busy_q) begin
      if (fifo_stat.credit) begin
        rd_req.issue = 1'b1;
        rd_req.last  = (cnt_q == LastIdx);
        u_acc_d      = u_acc_q + AccW'(u_inc_q);
        v_acc_d      = v_acc_q + AccW'(v_inc_q);
        cnt_d        = cnt_q + CntW'(1);
        if (cnt_q == LastIdx) begin
          busy_d = 1'b0;
          cnt_d  = '0;
        end
      end
    end else if (item_valid && item_ready) begin
      unique case (item.mode)
        MODE_LOAD: begin
          ram_we = 1'b1;
        end
        MODE_SPAN: begin
          rd_req.issue = 1'b1;
          ram_raddr    = {item.u_acc[FracW +: 8], item.v_acc[FracW +: 8]};
          u_acc_d      = item.u_acc + item.u_inc;
          v_acc_d      = item.v_acc + item.v_inc;
          u_inc_d      = IncW'(item.u_inc);
          v_inc_d      = IncW'(item.v_inc);
          cnt_d        = CntW'(1);
          busy_d       = 1'b1;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      u_acc_q <= '0;
      v_acc_q <= '0;
      u_inc_q <= '0;
      v_inc_q <= '0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      u_acc_q <= u_acc_d;
      v_acc_q <= v_acc_d;
      u_inc_q <= u_inc_d;
      v_inc_q <= v_inc_d;
    end
  end

  // texture store, written by loads and read by span pixels in item order
  stx_ram #(
    .Width (TexelW),
    .Depth (TexDepth)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item.texel_address),
    .wdata_i (item.texel_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // results wait here, so reads keep going while the sink stalls briefly
  stx_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_req_i    (rd_req),
    .rdata_i     (ram_rdata),
    .stat_o      (fifo_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a texel write never shares a cycle with a pixel read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.issue |-> !ram_we)
    else $error("texel write and pixel read in the same cycle");

  // the sequencer leaves a span only after reading its last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(rd_req.issue && rd_req.last))
    else $error("span ended without its last pixel");

  // reading the last pixel frees the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_req.issue && rd_req.last) |=> !busy_q)
    else $error("sequencer still busy after the last pixel");

endmodule

// ===== rtl/stx_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module stx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stx_step.sv =====
// three-stage step preparation: difference, reciprocal multiply, sign
`timescale 1ns / 1ps

module stx_step import stx_pkg::*; #(
  parameter int unsigned SPAN_LENGTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  stx_in_t   in_data_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output stx_item_t item_o
);

  // floor(x / L) = (x * ceil(2^s / L)) >> s, exact for x below 2^AccW
  localparam int unsigned Shift = AccW + $clog2(SPAN_LENGTH);
  localparam longint unsigned RecipL =
      ((64'd1 << Shift) + longint'(SPAN_LENGTH) - 1) / longint'(SPAN_LENGTH);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam int unsigned ProdW = CoordW + RecipW;
  localparam int unsigned PostShift = Shift - FracW;

  typedef struct packed {
    mode_e               mode;
    logic [TexAddrW-1:0] texel_address;
    logic [TexelW-1:0]   texel_value;
    logic [CoordW-1:0]   u_start;
    logic [CoordW-1:0]   v_start;
  } pass_t;

  logic vld_a_q, vld_b_q, vld_c_q;
  logic adv_a, adv_b, adv_c;

  pass_t pass_a_q, pass_b_q;
  logic u_neg_a_q, v_neg_a_q, u_neg_b_q, v_neg_b_q;
  logic [CoordW-1:0] u_mag_a_q, v_mag_a_q;
  logic [ProdW-1:0] u_prod_b_q, v_prod_b_q;
  stx_item_t item_c_q;

  logic [CoordW:0] u_diff, v_diff;
  logic [CoordW:0] u_abs, v_abs;
  logic [AccW-1:0] u_quot, v_quot;

  assign adv_c = item_ready_i || !vld_c_q;
  assign adv_b = adv_c || !vld_b_q;
  assign adv_a = adv_b || !vld_a_q;
  assign in_ready_o = adv_a;

  assign u_diff = {1'b0, in_data_i.u_end} - {1'b0, in_data_i.u_start};
  assign v_diff = {1'b0, in_data_i.v_end} - {1'b0, in_data_i.v_start};
  assign u_abs  = u_diff[CoordW] ? (~u_diff + 1'b1) : u_diff;
  assign v_abs  = v_diff[CoordW] ? (~v_diff + 1'b1) : v_diff;

  assign u_quot = AccW'(u_prod_b_q >> PostShift);
  assign v_quot = AccW'(v_prod_b_q >> PostShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_q <= in_valid_i;
      end
      if (adv_b) begin
        vld_b_q <= vld_a_q;
      end
      if (adv_c) begin
        vld_c_q <= vld_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      pass_a_q.mode          <= in_data_i.mode;
      pass_a_q.texel_address <= in_data_i.texel_address;
      pass_a_q.texel_value   <= in_data_i.texel_value;
      pass_a_q.u_start       <= in_data_i.u_start;
      pass_a_q.v_start       <= in_data_i.v_start;
      u_neg_a_q              <= u_diff[CoordW];
      v_neg_a_q              <= v_diff[CoordW];
      u_mag_a_q              <= u_abs[CoordW-1:0];
      v_mag_a_q              <= v_abs[CoordW-1:0];
    end
    if (adv_b && vld_a_q) begin
      pass_b_q   <= pass_a_q;
      u_neg_b_q  <= u_neg_a_q;
      v_neg_b_q  <= v_neg_a_q;
      u_prod_b_q <= ProdW'(u_mag_a_q) * ProdW'(Recip);
      v_prod_b_q <= ProdW'(v_mag_a_q) * ProdW'(Recip);
    end
    if (adv_c && vld_b_q) begin
      item_c_q.mode          <= pass_b_q.mode;
      item_c_q.texel_address <= pass_b_q.texel_address;
      item_c_q.texel_value   <= pass_b_q.texel_value;
      item_c_q.u_acc         <= {pass_b_q.u_start, {FracW{1'b0}}};
      item_c_q.v_acc         <= {pass_b_q.v_start, {FracW{1'b0}}};
      item_c_q.u_inc         <= u_neg_b_q ? -signed'(u_quot) : signed'(u_quot);
      item_c_q.v_inc         <= v_neg_b_q ? -signed'(v_quot) : signed'(v_quot);
    end
  end

  assign item_valid_o = vld_c_q;
  assign item_o       = item_c_q;

endmodule

// ===== rtl/stx_out_fifo.sv =====
// result fifo behind the texture ram with issue credit
`timescale 1ns / 1ps

module stx_out_fifo import stx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stx_rd_req_t       rd_req_i,
  input  logic [TexelW-1:0] rdata_i,
  output stx_fifo_stat_t    stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stx_out_t          out_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  stx_out_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d, occ;
  logic            pend_q, pend_last_q;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // read in flight counts against the free space
  assign occ           = cnt_q + CntW'(pend_q);
  assign stat_o.credit = (occ < CntW'(Depth));
  assign cnt_d         = cnt_q + CntW'(pend_q) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      pend_q      <= rd_req_i.issue;
      pend_last_q <= rd_req_i.last;
      cnt_q       <= cnt_d;
      if (pend_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem_q[wr_ptr_q] <= '{pixel: rdata_i, span_last: pend_last_q};
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the span texture interpolator
`timescale 1ns / 1ps

// texel predictor and pixel checker: keeps its own texture copy and a queue of
// the pixels each span transaction is expected to produce
class span_texel_board;
  int span_len;
  logic [stx_pkg::TexelW-1:0] texture [stx_pkg::TexDepth];
  bit                         written [stx_pkg::TexDepth];
  stx_pkg::stx_out_t          pending_pixels [$];
  int errors;
  int loads_seen;
  int spans_seen;
  int pixels_checked;

  function new(int n);
    span_len       = n;
    errors         = 0;
    loads_seen     = 0;
    spans_seen     = 0;
    pixels_checked = 0;
  endfunction

  // texture address of pixel k: row from integer u, column from integer v
  function logic [stx_pkg::TexAddrW-1:0] span_texel_address(stx_pkg::stx_in_t it, int k);
    int du;
    int dv;
    logic [stx_pkg::AccW-1:0] acc_u;
    logic [stx_pkg::AccW-1:0] acc_v;
    du    = (int'(it.u_end) - int'(it.u_start)) * 256 / span_len;
    dv    = (int'(it.v_end) - int'(it.v_start)) * 256 / span_len;
    acc_u = {it.u_start, 8'h00} + 24'(k * du);
    acc_v = {it.v_start, 8'h00} + 24'(k * dv);
    return {acc_u[15:8], acc_v[15:8]};
  endfunction

  function void note_item(stx_pkg::stx_in_t it);
    logic [stx_pkg::TexAddrW-1:0] a;
    stx_pkg::stx_out_t px;
    if (it.mode == stx_pkg::MODE_LOAD) begin
      texture[it.texel_address] = it.texel_value;
      written[it.texel_address] = 1'b1;
      loads_seen++;
    end else begin
      spans_seen++;
      for (int k = 0; k < span_len; k++) begin
        a            = span_texel_address(it, k);
        px.pixel     = texture[a];
        px.span_last = (k == span_len - 1);
        pending_pixels.push_back(px);
      end
    end
  endfunction

  function void check_pixel(stx_pkg::stx_out_t got);
    stx_pkg::stx_out_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected pixel %0h, last %0b", got.pixel, got.span_last);
      errors++;
      return;
    end
    want = pending_pixels.pop_front();
    pixels_checked++;
    if (got.pixel !== want.pixel) begin
      $error("pixel: expected %0h, actual %0h", want.pixel, got.pixel);
      errors++;
    end
    if (got.span_last !== want.span_last) begin
      $error("span_last: expected %0b, actual %0b", want.span_last, got.span_last);
      errors++;
    end
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction
endclass

module tb_top;
  import stx_pkg::*;

  localparam int SpanLen    = 8;
  localparam int CycleLimit = 400000;
  localparam int TailCycles = 16;   // room for the step pipeline and ram read, plus fifo slack
  localparam int PhaseItems = 50;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  stx_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  stx_out_t out_data;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int items_sent   = 0;
  int cycle_count  = 0;

  span_texel_board board;

  span_texture_interpolator #(
    .SPAN_LENGTH(SpanLen)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: a missing pixel or a hung handshake ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check every accepted pixel, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_pixel(out_data);
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // one input transaction: optional idle gap, then hold valid until accepted
  task automatic send_item(input stx_in_t item);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    board.note_item(item);
    items_sent++;
  endtask

  // texel write; the coordinate fields are don't-care so they get noise
  task automatic send_load(input logic [15:0] a, input logic [7:0] val);
    stx_in_t it;
    it.mode          = MODE_LOAD;
    it.texel_address = a;
    it.texel_value   = val;
    it.u_start       = 16'($urandom);
    it.u_end         = 16'($urandom);
    it.v_start       = 16'($urandom);
    it.v_end         = 16'($urandom);
    send_item(it);
  endtask

  // span render; any texel the span would touch that has never been written
  // gets a load first, so no read of undefined texture contents ever happens
  task automatic send_span(input logic [15:0] u0, input logic [15:0] u1,
                           input logic [15:0] v0, input logic [15:0] v1);
    stx_in_t it;
    logic [15:0] a;
    it.mode          = MODE_SPAN;
    it.texel_address = 16'($urandom);
    it.texel_value   = 8'($urandom);
    it.u_start       = u0;
    it.u_end         = u1;
    it.v_start       = v0;
    it.v_end         = v1;
    for (int k = 0; k < SpanLen; k++) begin
      a = board.span_texel_address(it, k);
      if (!board.written[a]) begin
        send_load(a, 8'($urandom));
      end
    end
    send_item(it);
  endtask

  // sender holds off until every predicted pixel has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // random traffic: compact spans reuse a small texture patch, local spans have
  // short steps anywhere, wide spans have arbitrary steps, plus stray loads
  task automatic run_random(input int count);
    int stop;
    int choice;
    logic [15:0] u0;
    logic [15:0] v0;
    stop = items_sent + count;
    while (items_sent < stop) begin
      choice = $urandom_range(99);
      if (choice < 15) begin
        send_load(16'($urandom), 8'($urandom));
      end else if (choice < 50) begin
        u0 = 16'($urandom_range(4, 11));
        v0 = 16'($urandom_range(4, 11));
        send_span(u0, u0 + 16'($urandom_range(8)) - 16'd4,
                  v0, v0 + 16'($urandom_range(8)) - 16'd4);
      end else if (choice < 75) begin
        u0 = 16'($urandom);
        v0 = 16'($urandom);
        send_span(u0, u0 + 16'($urandom_range(48)) - 16'd24,
                  v0, v0 + 16'($urandom_range(48)) - 16'd24);
      end else begin
        send_span(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    board = new(SpanLen);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles little, receiver stalls a lot
    in_idle_pct  = 27;
    out_idle_pct = 82;

    // directed: corner texels and value extremes
    send_load(16'h0000, 8'h00);
    send_load(16'hFFFF, 8'hFF);
    send_load(16'h00FF, 8'hA5);
    send_load(16'hFF00, 8'h5A);
    // zero step at both coordinate extremes, and at u 0000, v 00FF
    send_span(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_span(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_span(16'h0000, 16'h0000, 16'h00FF, 16'h00FF);
    // largest rising u step against largest falling v step
    send_span(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    // fractional steps, integer part changes mid-span
    send_span(16'h0010, 16'h0013, 16'h0020, 16'h001D);

    run_random(PhaseItems);
    drain();

    // phase two: the other way round
    in_idle_pct  = 82;
    out_idle_pct = 27;
    run_random(PhaseItems);
    drain();

    // phase three: full rate on both sides
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(PhaseItems);
    drain();
    repeat (TailCycles) @(posedge clk);

    $display("run covered %0d texel loads and %0d spans, %0d pixels checked",
             board.loads_seen, board.spans_seen, board.pixels_checked);
    $display("stall mixes sender/receiver: 27/82, 82/27 and 0/0 percent");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stx_pkg.sv
rtl/stx_ram.sv
rtl/stx_step.sv
rtl/stx_out_fifo.sv
rtl/span_texture_interpolator.sv
tb/tb_top.sv
